>>> hdl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and helpers for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // Depth of the command queue between decoder and serializer
    localparam int QDEPTH = 4;
    localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Characters the decoder looks for
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_U   = 8'h75;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // Surrogate ranges by the top six bits of a code unit
    localparam logic [5:0] SUR_HI_TAG = 6'b110110;
    localparam logic [5:0] SUR_LO_TAG = 6'b110111;
    localparam logic [20:0] SUP_BASE  = 21'h10000;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_UNTERM      = 3'd1,
        ERR_BAD_ESC     = 3'd2,
        ERR_BAD_HEX     = 3'd3,
        ERR_MISSING_LOW = 3'd4,
        ERR_BAD_LOW     = 3'd5,
        ERR_LONE_LOW    = 3'd6,
        ERR_CONTROL     = 3'd7
    } t_err;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_text;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       string_done;
        t_err       error_code;
        logic       last;
    } t_out;

    // One queued command: up to four data bytes, or a single done/error beat
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            is_data;
        logic            done;
        t_err            err;
    } t_cmd;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] b);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.val = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            h.val = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            h.val = 4'(b - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic t_cmd byte_cmd(input logic [7:0] b);
        t_cmd c;
        c          = '0;
        c.is_data  = 1'b1;
        c.bytes[0] = b;
        return c;
    endfunction

    function automatic t_cmd err_cmd(input t_err e);
        t_cmd c;
        c     = '0;
        c.err = e;
        return c;
    endfunction

    function automatic t_cmd done_cmd();
        t_cmd c;
        c      = '0;
        c.done = 1'b1;
        return c;
    endfunction

    function automatic t_cmd utf8_cmd(input logic [20:0] cp);
        t_cmd c;
        c         = '0;
        c.is_data = 1'b1;
        if (cp < 21'h80) begin
            c.bytes[0] = cp[7:0];
            c.last_idx = 2'd0;
        end else if (cp < 21'h800) begin
            c.bytes[0] = {3'b110, cp[10:6]};
            c.bytes[1] = {2'b10, cp[5:0]};
            c.last_idx = 2'd1;
        end else if (cp < 21'h10000) begin
            c.bytes[0] = {4'b1110, cp[15:12]};
            c.bytes[1] = {2'b10, cp[11:6]};
            c.bytes[2] = {2'b10, cp[5:0]};
            c.last_idx = 2'd2;
        end else begin
            c.bytes[0] = {5'b11110, cp[20:18]};
            c.bytes[1] = {2'b10, cp[17:12]};
            c.bytes[2] = {2'b10, cp[11:6]};
            c.bytes[3] = {2'b10, cp[5:0]};
            c.last_idx = 2'd3;
        end
        return c;
    endfunction

endpackage

>>> hdl/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Escape decoder: takes one body byte per beat, tracks escape and surrogate
// state and pushes a command per byte that produces output.
// ----------------------------------------------------------------------------
module jsu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  jsu_pkg::t_in  i_in,
    input  logic          i_full,
    output logic          o_push,
    output jsu_pkg::t_cmd o_cmd
);
    import jsu_pkg::*;

    typedef enum logic [2:0] {
        S_NORMAL,
        S_ESC,
        S_HI,
        S_WANT_BS,
        S_WANT_U,
        S_LO
    } t_state;

    t_state      r_state, n_state;
    logic [1:0]  r_cnt, n_cnt;
    logic [11:0] r_acc, n_acc;
    logic [9:0]  r_hs, n_hs;

    logic        accept;
    logic [7:0]  b;
    t_hex        hx;
    logic [15:0] cp_bmp;
    logic [20:0] cp_sup;
    logic        do_fail;
    t_err        fail_code;
    logic        go_idle;

    assign o_in_stall = i_full;
    assign accept     = i_in_valid && !i_full;
    assign b          = i_in.data_byte;
    assign hx         = hex_decode(b);
    assign cp_bmp     = {r_acc, hx.val};
    assign cp_sup     = SUP_BASE + {1'b0, r_hs, cp_bmp[9:0]};

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_acc     = r_acc;
        n_hs      = r_hs;
        o_push    = 1'b0;
        o_cmd     = '0;
        do_fail   = 1'b0;
        fail_code = ERR_NONE;
        go_idle   = 1'b0;

        if (accept) begin
            if (i_in.end_of_text) begin
                do_fail   = 1'b1;
                fail_code = ERR_UNTERM;
            end else begin
                unique case (r_state) inside
                    S_NORMAL: begin
                        if (b == CH_QUOTE) begin
                            o_push  = 1'b1;
                            o_cmd   = done_cmd();
                            go_idle = 1'b1;
                        end else if (b == CH_BSLASH) begin
                            n_state = S_ESC;
                        end else if (b < CH_SPACE) begin
                            do_fail   = 1'b1;
                            fail_code = ERR_CONTROL;
                        end else begin
                            o_push = 1'b1;
                            o_cmd  = byte_cmd(b);
                        end
                    end
                    S_ESC: begin
                        n_state = S_NORMAL;
                        o_push  = 1'b1;
                        unique case (b) inside
                            CH_QUOTE, CH_BSLASH, CH_SLASH: o_cmd = byte_cmd(b);
                            CH_LC_B: o_cmd = byte_cmd(CH_BS);
                            CH_LC_F: o_cmd = byte_cmd(CH_FF);
                            CH_LC_N: o_cmd = byte_cmd(CH_LF);
                            CH_LC_R: o_cmd = byte_cmd(CH_CR);
                            CH_LC_T: o_cmd = byte_cmd(CH_TAB);
                            CH_LC_U: begin
                                o_push  = 1'b0;
                                n_state = S_HI;
                                n_cnt   = 2'd0;
                                n_acc   = '0;
                            end
                            default: begin
                                o_push    = 1'b0;
                                do_fail   = 1'b1;
                                fail_code = ERR_BAD_ESC;
                            end
                        endcase
                    end
                    S_HI, S_LO: begin
                        if (!hx.ok) begin
                            do_fail   = 1'b1;
                            fail_code = ERR_BAD_HEX;
                        end else if (r_cnt != 2'd3) begin
                            n_acc = {r_acc[7:0], hx.val};
                            n_cnt = r_cnt + 2'd1;
                        end else if (r_state == S_HI) begin
                            if (cp_bmp[15:10] == SUR_HI_TAG) begin
                                n_hs    = cp_bmp[9:0];
                                n_acc   = '0;
                                n_cnt   = 2'd0;
                                n_state = S_WANT_BS;
                            end else if (cp_bmp[15:10] == SUR_LO_TAG) begin
                                do_fail   = 1'b1;
                                fail_code = ERR_LONE_LOW;
                            end else begin
                                o_push  = 1'b1;
                                o_cmd   = utf8_cmd({5'd0, cp_bmp});
                                go_idle = 1'b1;
                            end
                        end else begin
                            if (cp_bmp[15:10] != SUR_LO_TAG) begin
                                do_fail   = 1'b1;
                                fail_code = ERR_BAD_LOW;
                            end else begin
                                o_push  = 1'b1;
                                o_cmd   = utf8_cmd(cp_sup);
                                go_idle = 1'b1;
                            end
                        end
                    end
                    S_WANT_BS: begin
                        if (b != CH_BSLASH) begin
                            do_fail   = 1'b1;
                            fail_code = ERR_MISSING_LOW;
                        end else begin
                            n_state = S_WANT_U;
                        end
                    end
                    S_WANT_U: begin
                        if (b != CH_LC_U) begin
                            do_fail   = 1'b1;
                            fail_code = ERR_MISSING_LOW;
                        end else begin
                            n_state = S_LO;
                            n_cnt   = 2'd0;
                            n_acc   = '0;
                        end
                    end
                    default: begin
                        go_idle = 1'b1;
                    end
                endcase
            end

            if (do_fail) begin
                o_push  = 1'b1;
                o_cmd   = err_cmd(fail_code);
                go_idle = 1'b1;
            end
            if (go_idle) begin
                n_state = S_NORMAL;
                n_cnt   = 2'd0;
                n_acc   = '0;
                n_hs    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_NORMAL;
            r_cnt   <= 2'd0;
            r_acc   <= '0;
            r_hs    <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_acc   <= n_acc;
            r_hs    <= n_hs;
        end
    end

endmodule

>>> hdl/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// Small register queue of decoded commands between decoder and serializer.
// ----------------------------------------------------------------------------
module jsu_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jsu_pkg::t_cmd i_wdata,
    output logic          o_full,
    input  logic          i_pop,
    output jsu_pkg::t_cmd o_rdata,
    output logic          o_empty
);
    import jsu_pkg::*;

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr, r_rd;
    logic [QCW-1:0] r_cnt;

    assign o_full  = (r_cnt == QCW'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rd];

    function automatic logic [QAW-1:0] ptr_inc(input logic [QAW-1:0] p);
        return (p == QAW'(QDEPTH - 1)) ? '0 : p + QAW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - QCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

endmodule

>>> hdl/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Serializer: while the output is not stalled, walks the head command one
// beat per cycle into the output register and pops it after its last beat.
// ----------------------------------------------------------------------------
module jsu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  jsu_pkg::t_cmd i_head,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output jsu_pkg::t_out o_out
);
    import jsu_pkg::*;

    logic       r_out_valid;
    t_out       r_out;
    logic [1:0] r_idx;

    logic       adv;
    logic       take;
    logic       at_last;
    t_out       res;

    assign adv     = !r_out_valid || !i_out_stall;
    assign take    = adv && !i_empty;
    assign at_last = (r_idx == i_head.last_idx);
    assign o_pop   = take && at_last;

    always_comb begin
        res.out_byte    = i_head.is_data ? i_head.bytes[r_idx] : 8'd0;
        res.byte_valid  = i_head.is_data;
        res.string_done = i_head.done;
        res.error_code  = i_head.err;
        res.last        = at_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= 2'd0;
        end else if (adv) begin
            r_out_valid <= !i_empty;
            if (take) begin
                r_idx <= at_last ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> hdl/json_string_unescape_utf8_top.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_top
// JSON string body unescaper with UTF-8 output.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall / i_in): one body byte per beat,
// starting after the opening quote; end_of_text set ends the text.
// Output channel (o_out_valid / i_out_stall / o_out): decoded bytes, one per
// beat, or a single done or error beat; last marks the final beat caused by
// an input byte. Escape prefixes and leading hex digits produce no beat.
// A beat reaches o_out through the command queue and the output register.
// Throughput: one input byte per cycle unless o_in_stall is high. A \u
// escape expands to up to four output beats, drained at one per cycle by the
// serializer while not stalled; long multi-byte bursts run at the output rate.
// A four-entry command queue separates decoder and serializer; o_in_stall
// rises only when that queue is full.
// Reset (synchronous, active low) returns the decoder to the normal body
// state and empties the queue and output register.
// While i_out_stall is high the output beat holds; the decoder keeps taking
// bytes until the queue fills.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  jsu_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output jsu_pkg::t_out o_out
);
    import jsu_pkg::*;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    t_cmd q_wdata;
    t_cmd q_head;

    jsu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .i_full     (q_full),
        .o_push     (q_push),
        .o_cmd      (q_wdata)
    );

    jsu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rdata (q_head),
        .o_empty (q_empty)
    );

    jsu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

>>> hdl/jsu_checker.sv
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks for the JSON string unescaper, bound to the top level.
// ----------------------------------------------------------------------------
module jsu_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input jsu_pkg::t_out o_out
);
    import jsu_pkg::*;

    // A stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("output beat changed while stalled");

    // Reset empties the output and the queue
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output valid or input stall after reset");

    // Done and error beats carry no byte and close their burst
    a_status_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.string_done || o_out.error_code != ERR_NONE)
        |-> !o_out.byte_valid && o_out.out_byte == 8'd0 && o_out.last)
        else $error("malformed done or error beat");

    // A multi-byte burst continues without gaps
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out.last
        |=> o_out_valid && o_out.byte_valid)
        else $error("gap inside a UTF-8 burst");

endmodule

bind json_string_unescape_utf8_top jsu_checker u_jsu_checker (.*);
